### sv/xps_pkg.sv
package xps_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;

    localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] SM_MUL_A = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] SM_MUL_B = 64'h94D0_49BB_1331_11EB;

    localparam int unsigned SM_SHIFT_A = 30;
    localparam int unsigned SM_SHIFT_B = 27;
    localparam int unsigned SM_SHIFT_C = 31;

    localparam int unsigned XO_ROT_A   = 55;
    localparam int unsigned XO_SHIFT   = 14;
    localparam int unsigned XO_ROT_B   = 36;

    // Partial-product steps of the shared multiplier
    localparam logic [1:0] MS_LO_LO = 2'd0;
    localparam logic [1:0] MS_LO_HI = 2'd1;
    localparam logic [1:0] MS_HI_LO = 2'd2;
    localparam logic [1:0] MS_LAST  = 2'd3;

    typedef enum logic [1:0] {
        SD_IDLE,
        SD_MUL_A,
        SD_MUL_B
    } t_seed_state;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] prod;
    } t_mul_rsp;

endpackage

### sv/xps_mullo.sv
module xps_mullo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xps_pkg::t_mul_req i_req,
    output xps_pkg::t_mul_rsp o_rsp
);

    logic                         r_busy;
    logic                         r_done;
    logic [1:0]                   r_cnt;
    logic [xps_pkg::WORD_W-1:0]   r_a;
    logic [xps_pkg::WORD_W-1:0]   r_b;
    logic [xps_pkg::WORD_W-1:0]   r_prod;
    logic [xps_pkg::WORD_W-1:0]   r_acc;

    logic [xps_pkg::HALF_W-1:0]   op_x;
    logic [xps_pkg::HALF_W-1:0]   op_y;
    logic [xps_pkg::WORD_W-1:0]   n_prod;

    // Low 64 bits of a 64x64 product: lo*lo plus the two cross terms shifted up
    always_comb begin
        case (r_cnt)
            xps_pkg::MS_LO_LO: begin
                op_x = r_a[xps_pkg::HALF_W-1:0];
                op_y = r_b[xps_pkg::HALF_W-1:0];
            end
            xps_pkg::MS_LO_HI: begin
                op_x = r_a[xps_pkg::HALF_W-1:0];
                op_y = r_b[xps_pkg::WORD_W-1:xps_pkg::HALF_W];
            end
            xps_pkg::MS_HI_LO: begin
                op_x = r_a[xps_pkg::WORD_W-1:xps_pkg::HALF_W];
                op_y = r_b[xps_pkg::HALF_W-1:0];
            end
            default: begin
                op_x = '0;
                op_y = '0;
            end
        endcase
        n_prod = {{xps_pkg::HALF_W{1'b0}}, op_x} * {{xps_pkg::HALF_W{1'b0}}, op_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == xps_pkg::MS_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        if (r_busy) begin
            r_prod <= n_prod;
            // accumulate the product registered in the step before
            if (r_cnt == xps_pkg::MS_LO_HI) begin
                r_acc <= r_prod;
            end else if (r_cnt == xps_pkg::MS_HI_LO || r_cnt == xps_pkg::MS_LAST) begin
                r_acc[xps_pkg::WORD_W-1:xps_pkg::HALF_W] <=
                    r_acc[xps_pkg::WORD_W-1:xps_pkg::HALF_W] +
                    r_prod[xps_pkg::HALF_W-1:0];
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

### sv/xps_seeder.sv
module xps_seeder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [xps_pkg::WORD_W-1:0] i_seed,
    input  xps_pkg::t_mul_rsp          i_mul_rsp,
    output xps_pkg::t_mul_req          o_mul_req,
    output logic                       o_done,
    output logic [xps_pkg::WORD_W-1:0] o_word_zero,
    output logic [xps_pkg::WORD_W-1:0] o_word_one
);

    xps_pkg::t_seed_state         r_state;
    xps_pkg::t_seed_state         n_state;
    logic                         r_half;
    logic                         n_half;
    logic [xps_pkg::WORD_W-1:0]   r_x;
    logic [xps_pkg::WORD_W-1:0]   n_x;
    logic [xps_pkg::WORD_W-1:0]   r_z0;
    logic [xps_pkg::WORD_W-1:0]   n_z0;

    logic [xps_pkg::WORD_W-1:0]   z_base;
    logic [xps_pkg::WORD_W-1:0]   z_sum;
    logic [xps_pkg::WORD_W-1:0]   z_mix;
    logic [xps_pkg::WORD_W-1:0]   p_mix;
    logic [xps_pkg::WORD_W-1:0]   p_fin;

    assign z_base = (r_state == xps_pkg::SD_IDLE) ? i_seed : r_x;
    assign z_sum  = z_base + xps_pkg::SM_GAMMA;
    assign z_mix  = z_sum ^ (z_sum >> xps_pkg::SM_SHIFT_A);
    assign p_mix  = i_mul_rsp.prod ^ (i_mul_rsp.prod >> xps_pkg::SM_SHIFT_B);
    assign p_fin  = i_mul_rsp.prod ^ (i_mul_rsp.prod >> xps_pkg::SM_SHIFT_C);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xps_pkg::SD_IDLE;
            r_half  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_half  <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x  <= n_x;
        r_z0 <= n_z0;
    end

    always_comb begin
        n_state   = r_state;
        n_half    = r_half;
        n_x       = r_x;
        n_z0      = r_z0;
        o_mul_req = '0;
        o_done    = 1'b0;
        case (r_state)
            xps_pkg::SD_IDLE: begin
                if (i_start) begin
                    // keep seed + 1 for the second word
                    n_x             = i_seed + 64'd1;
                    n_half          = 1'b0;
                    o_mul_req.start = 1'b1;
                    o_mul_req.a     = z_mix;
                    o_mul_req.b     = xps_pkg::SM_MUL_A;
                    n_state         = xps_pkg::SD_MUL_A;
                end
            end
            xps_pkg::SD_MUL_A: begin
                if (i_mul_rsp.done) begin
                    o_mul_req.start = 1'b1;
                    o_mul_req.a     = p_mix;
                    o_mul_req.b     = xps_pkg::SM_MUL_B;
                    n_state         = xps_pkg::SD_MUL_B;
                end
            end
            xps_pkg::SD_MUL_B: begin
                if (i_mul_rsp.done) begin
                    if (!r_half) begin
                        n_z0            = p_fin;
                        n_half          = 1'b1;
                        o_mul_req.start = 1'b1;
                        o_mul_req.a     = z_mix;
                        o_mul_req.b     = xps_pkg::SM_MUL_A;
                        n_state         = xps_pkg::SD_MUL_A;
                    end else begin
                        o_done  = 1'b1;
                        n_state = xps_pkg::SD_IDLE;
                    end
                end
            end
            default: begin
                n_state = xps_pkg::SD_IDLE;
            end
        endcase
    end

    assign o_word_zero = r_z0;
    assign o_word_one  = p_fin;

endmodule

### sv/xoroshiro_prng_with_seeding.sv
// Channel   Valid        Stall         Word
// input     i_in_valid   o_in_stall    i_action, i_seed_value
// output    o_out_valid  i_out_stall   o_random_word
//
// A draw registers the sum and advances the state in one step, and a new draw can
// follow in the next cycle while the output register drains, unless a held result is stalled.
// A reseed runs on the shared 32x32 multiplier: splitmix64 twice, two 64-bit
// multiplies each, three partial products per multiply.
// After reset the block seeds itself from zero and holds o_in_stall high until seeding is done.
// o_in_stall is high while seeding and while a held result is stalled.
module xoroshiro_prng_with_seeding (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic signed [63:0] i_seed_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [63:0]        o_random_word
);

    logic                         r_boot;
    logic                         r_busy;
    logic                         r_out_valid;
    logic [xps_pkg::WORD_W-1:0]   r_w0;
    logic [xps_pkg::WORD_W-1:0]   r_w1;
    logic [xps_pkg::WORD_W-1:0]   r_out_word;

    logic                         in_acc;
    logic                         out_acc;
    logic                         draw;
    logic                         seed_start;
    logic [xps_pkg::WORD_W-1:0]   seed;
    logic                         seed_done;
    logic [xps_pkg::WORD_W-1:0]   seed_w0;
    logic [xps_pkg::WORD_W-1:0]   seed_w1;
    logic [xps_pkg::WORD_W-1:0]   mixed;
    logic [xps_pkg::WORD_W-1:0]   n_w0;
    logic [xps_pkg::WORD_W-1:0]   n_w1;

    xps_pkg::t_mul_req            mul_req;
    xps_pkg::t_mul_rsp            mul_rsp;

    assign o_in_stall = r_busy | (r_out_valid & i_out_stall);
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign out_acc    = r_out_valid & ~i_out_stall;
    assign draw       = in_acc & i_action;
    assign seed_start = r_boot | (in_acc & ~i_action);
    assign seed       = r_boot ? '0 : $unsigned(i_seed_value);

    assign mixed = r_w0 ^ r_w1;
    assign n_w0  = {r_w0[xps_pkg::WORD_W-xps_pkg::XO_ROT_A-1:0],
                    r_w0[xps_pkg::WORD_W-1:xps_pkg::WORD_W-xps_pkg::XO_ROT_A]}
                   ^ mixed ^ (mixed << xps_pkg::XO_SHIFT);
    assign n_w1  = {mixed[xps_pkg::WORD_W-xps_pkg::XO_ROT_B-1:0],
                    mixed[xps_pkg::WORD_W-1:xps_pkg::WORD_W-xps_pkg::XO_ROT_B]};

    xps_seeder u_seeder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (seed_start),
        .i_seed      (seed),
        .i_mul_rsp   (mul_rsp),
        .o_mul_req   (mul_req),
        .o_done      (seed_done),
        .o_word_zero (seed_w0),
        .o_word_one  (seed_w1)
    );

    xps_mullo u_mullo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot      <= 1'b1;
            r_busy      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_boot <= 1'b0;
            if (seed_start) begin
                r_busy <= 1'b1;
            end else if (seed_done) begin
                r_busy <= 1'b0;
            end
            if (draw) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (seed_done) begin
            r_w0 <= seed_w0;
            r_w1 <= seed_w1;
        end else if (draw) begin
            // hand out the sum, then advance
            r_out_word <= r_w0 + r_w1;
            r_w0       <= n_w0;
            r_w1       <= n_w1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_random_word = r_out_word;

endmodule
